[src/bwl_pkg.sv]
package bwl_pkg;

  // Operation codes carried in the action field.
  localparam logic [3:0] ACT_NOT  = 4'd0;
  localparam logic [3:0] ACT_AND  = 4'd1;
  localparam logic [3:0] ACT_OR   = 4'd2;
  localparam logic [3:0] ACT_XOR  = 4'd3;
  localparam logic [3:0] ACT_TEST = 4'd4;
  localparam logic [3:0] ACT_SHL  = 4'd5;
  localparam logic [3:0] ACT_SHR  = 4'd6;
  localparam logic [3:0] ACT_SAR  = 4'd7;
  localparam logic [3:0] ACT_ROL  = 4'd8;
  localparam logic [3:0] ACT_ROR  = 4'd9;
  localparam logic [3:0] ACT_RCL  = 4'd10;
  localparam logic [3:0] ACT_RCR  = 4'd11;

  // Bit positions in the flag update mask.
  localparam int unsigned FLG_CF = 0;
  localparam int unsigned FLG_OF = 1;
  localparam int unsigned FLG_ZF = 2;
  localparam int unsigned FLG_SF = 3;
  localparam int unsigned FLG_PF = 4;

  // Fully shifted counts: one beyond the operand width.
  localparam logic [4:0] SAT_BYTE = 5'd9;
  localparam logic [4:0] SAT_WORD = 5'd17;

  localparam logic [15:0] MASK_BYTE = 16'h00FF;
  localparam logic [15:0] MASK_WORD = 16'hFFFF;

  typedef struct packed {
    logic [3:0] action;
    logic       is_word;
  } bwl_ctl_t;

  typedef struct packed {
    logic orig_top;   // top bit of the operand before any step
    logic cnt_one;    // the requested count was exactly one
    logic cnt_zero;   // the requested count was zero
  } bwl_info_t;

  typedef struct packed {
    logic [15:0] result;
    logic        write_back;
    logic        carry_out;
    logic        overflow_out;
    logic        zero_out;
    logic        sign_out;
    logic        parity_out;
    logic [4:0]  flags_updated;
  } bwl_res_t;

endpackage

[src/bwl_if.sv]
interface bwl_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic        is_word;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [7:0]  count;
  logic        carry_in;

  modport source (output valid, action, is_word, operand_a, operand_b, count, carry_in,
                  input ready);
  modport sink (input valid, action, is_word, operand_a, operand_b, count, carry_in,
                output ready);
endinterface

interface bwl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        write_back;
  logic        carry_out;
  logic        overflow_out;
  logic        zero_out;
  logic        sign_out;
  logic        parity_out;
  logic [4:0]  flags_updated;

  modport source (output valid, result, write_back, carry_out, overflow_out, zero_out,
                  sign_out, parity_out, flags_updated, input ready);
  modport sink (input valid, result, write_back, carry_out, overflow_out, zero_out,
                sign_out, parity_out, flags_updated, output ready);
endinterface

[src/byte_word_logic_shift_rotate_alu_core.sv]
// Channel  Dir  Handshake      Payload
// in_i     in   valid / ready  action, is_word, operand_a, operand_b, count, carry_in
// out_o    out  valid / ready  result, write_back, carry_out, overflow_out, zero_out,
//                              sign_out, parity_out, flags_updated
//
// The sequencer takes an accepted item through n one-bit steps and then into the
// result register, where n is 0 for logic ops, min(count, width + 1) for shifts,
// count mod width for ROL/ROR and the full count (up to 255) for RCL/RCR.
// All steps run through the single one-bit shift/rotate step unit.
// rst_ni clears the sequencer and the result valid; payload registers are not reset.
// in_i.ready is high only while the sequencer is idle; a stalled result holds in the
// output register, and a finished item waits there before the next one may finish.
module byte_word_logic_shift_rotate_alu_core import bwl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bwl_in_if.sink    in_i,
  bwl_out_if.source out_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic        state_q, state_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] val_q, val_d;
  logic [15:0] opb_q;
  logic        cf_q, cf_d;
  bwl_ctl_t    ctl_q;
  bwl_info_t   info_q;
  logic        out_vld_q, out_vld_d;
  bwl_res_t    out_q;

  logic        accept;
  logic        finish;
  logic        out_free;
  logic [15:0] in_mask;
  logic [15:0] in_a;
  logic [4:0]  sat;
  logic [7:0]  load_cnt;
  logic [15:0] step_val;
  logic        step_cf;
  bwl_res_t    fin_res;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  // The item is done once all steps ran and the result register can take it.
  assign finish   = (state_q == S_RUN) && (cnt_q == 8'd0) && out_free;

  assign in_i.ready = (state_q == S_IDLE);

  assign in_mask = in_i.is_word ? MASK_WORD : MASK_BYTE;
  assign in_a    = in_i.operand_a & in_mask;
  assign sat     = in_i.is_word ? SAT_WORD : SAT_BYTE;

  // Number of one-bit steps. Shifts stop once the operand is fully shifted out,
  // plain rotates reduce modulo the width, and rotates through carry walk the
  // whole count since their period is width plus one.
  always_comb begin
    case (in_i.action)
      ACT_SHL, ACT_SHR, ACT_SAR: begin
        load_cnt = (in_i.count > {3'd0, sat}) ? {3'd0, sat} : in_i.count;
      end
      ACT_ROL, ACT_ROR: begin
        load_cnt = in_i.is_word ? {4'd0, in_i.count[3:0]} : {5'd0, in_i.count[2:0]};
      end
      ACT_RCL, ACT_RCR: begin
        load_cnt = in_i.count;
      end
      default: begin
        load_cnt = 8'd0;
      end
    endcase
  end

  bwl_step u_step (
    .ctl_i (ctl_q),
    .val_i (val_q),
    .cf_i  (cf_q),
    .val_o (step_val),
    .cf_o  (step_cf)
  );

  bwl_flags u_flags (
    .ctl_i  (ctl_q),
    .info_i (info_q),
    .val_i  (val_q),
    .opb_i  (opb_q),
    .cf_i   (cf_q),
    .res_o  (fin_res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    cf_d      = cf_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          cnt_d   = load_cnt;
          val_d   = in_a;
          cf_d    = in_i.carry_in;
        end
      end
      S_RUN: begin
        if (cnt_q != 8'd0) begin
          cnt_d = cnt_q - 8'd1;
          val_d = step_val;
          cf_d  = step_cf;
        end else if (finish) begin
          state_d   = S_IDLE;
          out_vld_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cf_q  <= cf_d;
    if (accept) begin
      opb_q           <= in_i.operand_b & in_mask;
      ctl_q.action    <= in_i.action;
      ctl_q.is_word   <= in_i.is_word;
      info_q.orig_top <= in_i.is_word ? in_i.operand_a[15] : in_i.operand_a[7];
      info_q.cnt_one  <= (in_i.count == 8'd1);
      info_q.cnt_zero <= (in_i.count == 8'd0);
    end
    if (finish) begin
      out_q <= fin_res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.result        = out_q.result;
  assign out_o.write_back    = out_q.write_back;
  assign out_o.carry_out     = out_q.carry_out;
  assign out_o.overflow_out  = out_q.overflow_out;
  assign out_o.zero_out      = out_q.zero_out;
  assign out_o.sign_out      = out_q.sign_out;
  assign out_o.parity_out    = out_q.parity_out;
  assign out_o.flags_updated = out_q.flags_updated;

`ifndef SYNTHESIS
  // An accepted item always starts the sequencer.
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN))
    else $error("accepted item did not start the sequencer");

  // Each step consumes exactly one count.
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (cnt_q != 8'd0) |=> (cnt_q == $past(cnt_q) - 8'd1))
    else $error("step counter did not decrement by one");

  // The sequencer only goes idle with the step counter drained.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q == 8'd0))
    else $error("idle with steps left");

  // A finished item shows up on the output in the next cycle.
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_vld_q && (state_q == S_IDLE)))
    else $error("finished item not presented");
`endif

endmodule

[src/bwl_step.sv]
module bwl_step import bwl_pkg::*; (
  input  bwl_ctl_t    ctl_i,
  input  logic [15:0] val_i,
  input  logic        cf_i,
  output logic [15:0] val_o,
  output logic        cf_o
);

  logic [15:0] mask;
  logic        msb;
  logic [15:0] shl1;
  logic [15:0] shr1;

  // Places one bit at the top position of the current width.
  function automatic logic [15:0] at_top(input logic bit_v, input logic word);
    return word ? {bit_v, 15'd0} : {8'd0, bit_v, 7'd0};
  endfunction

  assign mask = ctl_i.is_word ? MASK_WORD : MASK_BYTE;
  assign msb  = ctl_i.is_word ? val_i[15] : val_i[7];
  assign shl1 = {val_i[14:0], 1'b0} & mask;
  assign shr1 = {1'b0, val_i[15:1]};

  always_comb begin
    val_o = val_i;
    cf_o  = cf_i;
    case (ctl_i.action)
      ACT_SHL: begin
        val_o = shl1;
        cf_o  = msb;
      end
      ACT_SHR: begin
        val_o = shr1;
        cf_o  = val_i[0];
      end
      ACT_SAR: begin
        val_o = shr1 | at_top(msb, ctl_i.is_word);
        cf_o  = val_i[0];
      end
      ACT_ROL: begin
        val_o = shl1 | {15'd0, msb};
        cf_o  = msb;
      end
      ACT_ROR: begin
        val_o = shr1 | at_top(val_i[0], ctl_i.is_word);
        cf_o  = val_i[0];
      end
      ACT_RCL: begin
        val_o = shl1 | {15'd0, cf_i};
        cf_o  = msb;
      end
      ACT_RCR: begin
        val_o = shr1 | at_top(cf_i, ctl_i.is_word);
        cf_o  = val_i[0];
      end
      default: begin
        val_o = val_i;
        cf_o  = cf_i;
      end
    endcase
  end

endmodule

[src/bwl_flags.sv]
module bwl_flags import bwl_pkg::*; (
  input  bwl_ctl_t    ctl_i,
  input  bwl_info_t   info_i,
  input  logic [15:0] val_i,
  input  logic [15:0] opb_i,
  input  logic        cf_i,
  output bwl_res_t    res_o
);

  logic [15:0] mask;
  logic [15:0] r;
  logic        wb;
  logic        cf;
  logic        of;
  logic [4:0]  upd;
  logic        r_top;
  logic        v_top;
  logic        v_next;

  assign mask   = ctl_i.is_word ? MASK_WORD : MASK_BYTE;
  assign r_top  = ctl_i.is_word ? r[15] : r[7];
  // Shifts and rotates return the stepped value unchanged, so their flags can
  // be taken straight from it.
  assign v_top  = ctl_i.is_word ? val_i[15] : val_i[7];
  assign v_next = ctl_i.is_word ? val_i[14] : val_i[6];

  always_comb begin
    r   = val_i;
    wb  = 1'b1;
    cf  = 1'b0;
    of  = 1'b0;
    upd = 5'd0;
    case (ctl_i.action)
      ACT_NOT: begin
        r = ~val_i & mask;
      end
      ACT_AND, ACT_OR, ACT_XOR, ACT_TEST: begin
        if (ctl_i.action == ACT_OR) begin
          r = val_i | opb_i;
        end else if (ctl_i.action == ACT_XOR) begin
          r = val_i ^ opb_i;
        end else begin
          r = val_i & opb_i;
        end
        wb  = (ctl_i.action != ACT_TEST);
        upd = 5'b11111;
      end
      ACT_SHL, ACT_SHR, ACT_SAR: begin
        cf = cf_i;
        if (ctl_i.action == ACT_SHL) begin
          of = v_top ^ cf_i;
        end else if (ctl_i.action == ACT_SHR) begin
          of = info_i.orig_top;
        end else begin
          of = 1'b0;
        end
        if (!info_i.cnt_zero) begin
          upd[FLG_CF] = 1'b1;
          upd[FLG_OF] = info_i.cnt_one;
          upd[FLG_ZF] = 1'b1;
          upd[FLG_SF] = 1'b1;
          upd[FLG_PF] = 1'b1;
        end
      end
      ACT_ROL, ACT_ROR, ACT_RCL, ACT_RCR: begin
        // Plain rotates take CF from the final value, so a count that wraps
        // to a multiple of the width still reports the right bit.
        if (ctl_i.action == ACT_ROL) begin
          cf = val_i[0];
          of = v_top ^ val_i[0];
        end else if (ctl_i.action == ACT_ROR) begin
          cf = v_top;
          of = v_top ^ v_next;
        end else if (ctl_i.action == ACT_RCL) begin
          cf = cf_i;
          of = v_top ^ cf_i;
        end else begin
          cf = cf_i;
          of = v_top ^ v_next;
        end
        if (!info_i.cnt_zero) begin
          upd[FLG_CF] = 1'b1;
          upd[FLG_OF] = info_i.cnt_one;
        end
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.result        = r & mask;
    res_o.write_back    = wb;
    res_o.carry_out     = upd[FLG_CF] & cf;
    res_o.overflow_out  = upd[FLG_OF] & of;
    res_o.zero_out      = upd[FLG_ZF] & ((r & mask) == 16'd0);
    res_o.sign_out      = upd[FLG_SF] & r_top;
    res_o.parity_out    = upd[FLG_PF] & ~(^r[7:0]);
    res_o.flags_updated = upd;
  end

endmodule

[bench/byte_word_logic_shift_rotate_alu_core_test.sv]
module byte_word_logic_shift_rotate_alu_core_test;
  import bwl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The two codes at the ends of the unused action range (12 to 15). The block
  // must pass operand_a through on them without a write back or any flag.
  localparam logic [3:0] ACT_UNUSED_LO = 4'd12;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  // Flag update masks that come up in the typed rows of the directed table.
  localparam logic [4:0] UPD_NONE  = 5'b00000;
  localparam logic [4:0] UPD_ALL   = 5'b11111;
  localparam logic [4:0] UPD_SHIFT = 5'b11101;  // CF, ZF, SF and PF, but no OF

  localparam int unsigned NUM_DIRECTED   = 25;
  localparam int unsigned OPS_PER_PHASE  = 400;
  localparam int unsigned STALL_AT_ITEM  = NUM_DIRECTED + 100;
  localparam int unsigned STALL_CYCLES   = 200;
  // The slowest item is RCL or RCR with a count of 255, which walks the whole count
  // one bit at a time before its result. The settle time covers that with room.
  localparam int unsigned SETTLE_CYCLES  = 300;
  // Longest quiet spell in a correct run: one slow item, plus the long output
  // stall, plus random stalls on both sides. The limit is several times that.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // One input item as it is placed on the input channel.
  typedef struct packed {
    logic [3:0]  action;
    logic        is_word;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [7:0]  count;
    logic        carry_in;
  } alu_op_t;

  // A row of the directed table. Where fixed is set, the outcome is typed in
  // below; otherwise it comes from the predictor like the random items do.
  typedef struct {
    alu_op_t  op;
    bit       fixed;
    bwl_res_t want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bwl_in_if  in_ch ();
  bwl_out_if out_ch ();

  byte_word_logic_shift_rotate_alu_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Outcomes of accepted items, oldest first, waiting for the block to return them.
  bwl_res_t    outcomes_due[$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned word_items = 0;
  int unsigned long_stalls = 0;
  int unsigned quiet_cycles = 0;
  int unsigned action_seen[16];
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;

  // Directed rows: every operation, both widths, the operand extremes, zero
  // counts, counts at and beyond the width, count one for the OF rule, the
  // 8-bit SAR sign fill, rotates through carry over the full width plus one,
  // and both ends of the unused action range.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{ACT_NOT,  1'b1, 16'h0000, 16'h0000, 8'd0,   1'b0}, 1'b1,
      '{16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}},
    '{'{ACT_NOT,  1'b0, 16'hFFFF, 16'h0000, 8'd0,   1'b0}, 1'b1,
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}},
    '{'{ACT_AND,  1'b1, 16'hFFFF, 16'h0000, 8'd1,   1'b1}, 1'b1,
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, UPD_ALL}},
    '{'{ACT_OR,   1'b1, 16'h8000, 16'h0001, 8'd0,   1'b1}, 1'b1,
      '{16'h8001, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, UPD_ALL}},
    '{'{ACT_XOR,  1'b0, 16'hFF55, 16'h00FF, 8'd0,   1'b0}, 1'b0, '0},
    '{'{ACT_TEST, 1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 1'b0}, 1'b1,
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, UPD_ALL}},
    '{'{ACT_SHL,  1'b1, 16'h1234, 16'h0000, 8'd0,   1'b1}, 1'b1,
      '{16'h1234, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}},
    '{'{ACT_SHL,  1'b0, 16'h0081, 16'h0000, 8'd1,   1'b0}, 1'b0, '0},
    '{'{ACT_SHL,  1'b1, 16'hFFFF, 16'h0000, 8'd17,  1'b1}, 1'b1,
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, UPD_SHIFT}},
    '{'{ACT_SHL,  1'b1, 16'hFFFF, 16'h0000, 8'd255, 1'b0}, 1'b1,
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, UPD_SHIFT}},
    '{'{ACT_SHR,  1'b1, 16'h8001, 16'h0000, 8'd1,   1'b0}, 1'b0, '0},
    '{'{ACT_SHR,  1'b0, 16'h00FF, 16'h0000, 8'd9,   1'b0}, 1'b1,
      '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, UPD_SHIFT}},
    '{'{ACT_SAR,  1'b0, 16'h0080, 16'h0000, 8'd3,   1'b0}, 1'b0, '0},
    '{'{ACT_SAR,  1'b1, 16'h8000, 16'h0000, 8'd255, 1'b0}, 1'b1,
      '{16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, UPD_SHIFT}},
    '{'{ACT_SAR,  1'b1, 16'h4000, 16'h0000, 8'd1,   1'b1}, 1'b0, '0},
    '{'{ACT_ROL,  1'b0, 16'h0081, 16'h0000, 8'd1,   1'b0}, 1'b0, '0},
    '{'{ACT_ROL,  1'b1, 16'h8001, 16'h0000, 8'd16,  1'b0}, 1'b0, '0},
    '{'{ACT_ROR,  1'b1, 16'h0001, 16'h0000, 8'd255, 1'b1}, 1'b0, '0},
    '{'{ACT_RCL,  1'b0, 16'h00A5, 16'h0000, 8'd9,   1'b1}, 1'b0, '0},
    '{'{ACT_RCL,  1'b1, 16'h4000, 16'h0000, 8'd1,   1'b0}, 1'b0, '0},
    '{'{ACT_RCR,  1'b1, 16'h0001, 16'h0000, 8'd17,  1'b1}, 1'b0, '0},
    '{'{ACT_RCR,  1'b0, 16'h00C3, 16'h0000, 8'd255, 1'b1}, 1'b0, '0},
    '{'{ACT_RCR,  1'b1, 16'hBEEF, 16'h0000, 8'd0,   1'b1}, 1'b1,
      '{16'hBEEF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}},
    '{'{ACT_UNUSED_LO, 1'b1, 16'h1234, 16'h5678, 8'd3, 1'b1}, 1'b1,
      '{16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}},
    '{'{ACT_UNUSED_HI, 1'b0, 16'hABCD, 16'hFFFF, 8'd1, 1'b0}, 1'b1,
      '{16'h00CD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UPD_NONE}}
  };

  // Computes what the block returns for one item. All arithmetic is done in
  // 32 bits so that shifts by the full width, or width plus one, stay defined.
  function automatic bwl_res_t compute_alu_outcome(alu_op_t op);
    bwl_res_t    res;
    int unsigned width, cnt, k, span;
    logic [31:0] msk, top, a, b, r, v, rv, vmsk;
    logic        cf, of, wb, sgn;
    logic [4:0]  upd;
    width = op.is_word ? 16 : 8;
    msk   = op.is_word ? 32'(MASK_WORD) : 32'(MASK_BYTE);
    top   = 32'd1 << (width - 1);
    a     = 32'(op.operand_a) & msk;
    b     = 32'(op.operand_b) & msk;
    cnt   = op.count;
    r     = a;
    wb    = 1'b1;
    cf    = 1'b0;
    of    = 1'b0;
    upd   = '0;
    case (op.action)
      ACT_NOT: begin
        r = ~a & msk;
      end
      ACT_AND, ACT_OR, ACT_XOR, ACT_TEST: begin
        if (op.action == ACT_OR) r = a | b;
        else if (op.action == ACT_XOR) r = a ^ b;
        else r = a & b;
        wb  = (op.action != ACT_TEST);
        upd = '1;
      end
      ACT_SHL, ACT_SHR, ACT_SAR: begin
        if (cnt != 0) begin
          if (op.action == ACT_SHL) begin
            // Past the width everything has been shifted out, carry included.
            if (cnt <= width) begin
              cf = a[width - cnt];
              r  = (a << cnt) & msk;
            end else begin
              cf = 1'b0;
              r  = '0;
            end
            of = ((r & top) != 0) ^ cf;
          end else if (op.action == ACT_SHR) begin
            if (cnt <= width) begin
              cf = a[cnt - 1];
              r  = a >> cnt;
            end else begin
              cf = 1'b0;
              r  = '0;
            end
            of = ((a & top) != 0);
          end else begin
            // The sign fill comes from the top bit of the operand width, bit 7
            // for a byte.
            sgn = ((a & top) != 0);
            if (cnt >= width) begin
              cf = sgn;
              r  = sgn ? msk : '0;
            end else begin
              cf = a[cnt - 1];
              r  = (a >> cnt) | (sgn ? (msk & ~(msk >> cnt)) : '0);
            end
            of = 1'b0;
          end
          upd[FLG_CF] = 1'b1;
          upd[FLG_ZF] = 1'b1;
          upd[FLG_SF] = 1'b1;
          upd[FLG_PF] = 1'b1;
          upd[FLG_OF] = (cnt == 1);
        end
      end
      ACT_ROL, ACT_ROR: begin
        if (cnt != 0) begin
          k = cnt % width;
          if (op.action == ACT_ROL) begin
            r  = ((a << k) | (a >> (width - k))) & msk;
            cf = r[0];
            of = ((r & top) != 0) ^ cf;
          end else begin
            r  = ((a >> k) | (a << (width - k))) & msk;
            cf = ((r & top) != 0);
            of = cf ^ r[width - 2];
          end
          upd[FLG_CF] = 1'b1;
          upd[FLG_OF] = (cnt == 1);
        end
      end
      ACT_RCL, ACT_RCR: begin
        if (cnt != 0) begin
          // The carry sits above the operand, and the pair turns as one value
          // of width plus one bits.
          span = width + 1;
          vmsk = (msk << 1) | 32'd1;
          v    = (32'(op.carry_in) << width) | a;
          k    = cnt % span;
          if (op.action == ACT_RCL) rv = ((v << k) | (v >> (span - k))) & vmsk;
          else rv = ((v >> k) | (v << (span - k))) & vmsk;
          r  = rv & msk;
          cf = rv[width];
          if (op.action == ACT_RCL) of = r[width - 1] ^ cf;
          else of = r[width - 1] ^ r[width - 2];
          upd[FLG_CF] = 1'b1;
          upd[FLG_OF] = (cnt == 1);
        end
      end
      default: begin
        wb = 1'b0;
      end
    endcase
    r &= msk;
    res.result        = r[15:0];
    res.write_back    = wb;
    res.carry_out     = upd[FLG_CF] & cf;
    res.overflow_out  = upd[FLG_OF] & of;
    res.zero_out      = upd[FLG_ZF] & (r == 0);
    res.sign_out      = upd[FLG_SF] & ((r & top) != 0);
    res.parity_out    = upd[FLG_PF] & ~(^r[7:0]);
    res.flags_updated = upd;
    return res;
  endfunction

  // Operands lean toward the values where flags and sign fills change.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h0080;
      5: return 16'h007F;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Counts are mostly small or near the width, so that slow rotates through
  // carry stay rare, with an occasional count anywhere up to 255.
  function automatic alu_op_t random_op();
    alu_op_t     op;
    int unsigned reach;
    if ($urandom_range(19) == 0) op.action = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    else op.action = 4'($urandom_range(ACT_RCR, ACT_NOT));
    op.is_word   = 1'($urandom_range(1));
    op.operand_a = pick_operand();
    op.operand_b = pick_operand();
    op.carry_in  = 1'($urandom_range(1));
    reach = op.is_word ? 18 : 10;
    case ($urandom_range(9))
      0, 1, 2, 3: op.count = 8'($urandom_range(2));
      4, 5, 6, 7: op.count = 8'($urandom_range(reach));
      default:    op.count = 8'($urandom_range(255));
    endcase
    return op;
  endfunction

  // Offers one item, with random idle cycles first, and files its expected
  // outcome once the block has taken it. It is entered and left at a rising edge.
  task automatic issue_op(alu_op_t op, bit fixed, bwl_res_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= op.action;
    in_ch.is_word   <= op.is_word;
    in_ch.operand_a <= op.operand_a;
    in_ch.operand_b <= op.operand_b;
    in_ch.count     <= op.count;
    in_ch.carry_in  <= op.carry_in;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    outcomes_due.push_back(fixed ? want : compute_alu_outcome(op));
    items_sent++;
    action_seen[op.action]++;
    if (op.is_word) word_items++;
  endtask

  // Stops offering and waits until the block has returned every outcome.
  task automatic drain_outcomes();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endtask

  // Sender: reset, then the directed table, then three random phases with
  // different idle patterns. Each phase ends with a full drain.
  initial begin
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_NOT;
    in_ch.is_word   <= 1'b0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    in_ch.count     <= '0;
    in_ch.carry_in  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 30;
    out_idle_pct = 60;
    foreach (directed_rows[i]) begin
      issue_op(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].want);
    end
    drain_outcomes();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin in_idle_pct = 30; out_idle_pct = 60; end
        1: begin in_idle_pct = 60; out_idle_pct = 30; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        issue_op(random_op(), 1'b0, '0);
      end
      drain_outcomes();
    end

    // Give a result that should not exist the time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (outcomes_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
    end

    begin
      int unsigned codes_hit;
      codes_hit = 0;
      foreach (action_seen[i]) if (action_seen[i] != 0) codes_hit++;
      $display("Run covered %0d items (%0d word, %0d byte) over %0d of 16 action codes,",
               items_sent, word_items, items_sent - word_items, codes_hit);
      $display("with %0d results checked and %0d long output stalls while input was offered.",
               results_checked, long_stalls);
    end
    if (errors == 0) begin
      $display("byte_word_logic_shift_rotate_alu_core: match");
    end else begin
      $display("byte_word_logic_shift_rotate_alu_core: mismatch");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off in the first random
  // phase. The sender keeps offering during it, so the result register and the
  // sequencer both fill and the input stalls.
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!stall_done && items_sent >= STALL_AT_ITEM) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_done = 1'b1;
        long_stalls++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Checker: every result taken from the block is matched against the oldest
  // expected outcome, one field at a time.
  always @(posedge clk_i) begin
    bwl_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: result 'h%0h arrived with no item outstanding",
                 $time, out_ch.result);
      end else begin
        want = outcomes_due.pop_front();
        results_checked++;
        check_field("result",        want.result,        out_ch.result);
        check_field("write_back",    want.write_back,    out_ch.write_back);
        check_field("carry_out",     want.carry_out,     out_ch.carry_out);
        check_field("overflow_out",  want.overflow_out,  out_ch.overflow_out);
        check_field("zero_out",      want.zero_out,      out_ch.zero_out);
        check_field("sign_out",      want.sign_out,      out_ch.sign_out);
        check_field("parity_out",    want.parity_out,    out_ch.parity_out);
        check_field("flags_updated", want.flags_updated, out_ch.flags_updated);
      end
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("byte_word_logic_shift_rotate_alu_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[filelist.f]
src/bwl_pkg.sv
src/bwl_if.sv
src/bwl_step.sv
src/bwl_flags.sv
src/byte_word_logic_shift_rotate_alu_core.sv
bench/byte_word_logic_shift_rotate_alu_core_test.sv
